@@ sv/uvs_pkg.sv @@
// Shared types, constants and tables for the UV-sphere vertex generator.
// Used by every module of the block but uvs_delay; depends on nothing else.
`default_nettype none
package uvs_pkg;

  localparam int MAX_RINGS_DEF     = 256;
  localparam int MAX_SECTORS_DEF   = 256;
  localparam int FRACTION_BITS_DEF = 14;

  localparam int IN_W       = 8;   // ring and sector number width
  localparam int REG_W      = 9;   // count register width
  localparam int CFG_ADDR_W = 1;
  localparam int CNT_W      = 11;  // clamped counts and divisors
  localparam int PHASE_W    = 32;
  localparam int TEX_FRAC   = 16;
  localparam int TEX_W      = TEX_FRAC + 1;
  localparam int POS_W      = 16;
  localparam int IDX_W      = 16;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 152;
  localparam int OUT_TUSER_W = 2;

  localparam int          CORDIC_STEPS = 30;
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
  localparam logic [31:0] CORDIC_START = 32'd652032874;

  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RING_COUNT   = 1'b0,
    REG_SECTOR_COUNT = 1'b1
  } cfg_reg_t;

  // Index and flag results, worked out early and carried to the output.
  typedef struct packed {
    logic             err;
    logic             quad;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] right;
    logic [IDX_W-1:0] diag;
    logic [IDX_W-1:0] below;
  } side_t;

endpackage
`default_nettype wire

@@ sv/uvs_delay.sv @@
// Enabled shift line that keeps side data in step with the main pipeline.
// Depends on nothing but its parameters.
`default_nettype none
module uvs_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] stage_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) stage_r[i] <= '0;
    end else if (en) begin
      stage_r[0] <= d;
      for (int i = 1; i < N; i++) stage_r[i] <= stage_r[i-1];
    end
  end

  assign q = stage_r[N-1];
endmodule
`default_nettype wire

@@ sv/uvs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for (x*2^K + o) / d
// with x no greater than d. Uses uvs_pkg.
`default_nettype none
module uvs_div #(
  parameter int K = 32
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [uvs_pkg::IN_W-1:0]   x,
  input  wire logic [uvs_pkg::CNT_W-1:0]  d,
  input  wire logic [K-1:0]               o,
  output logic      [K:0]                 q
);
  import uvs_pkg::*;

  logic [CNT_W-1:0] rem_r [K+1];
  logic [CNT_W-1:0] d_r   [K+1];
  logic [K-1:0]     o_r   [K+1];
  logic [K:0]       q_r   [K+1];
  logic             top;

  // Whole part of the quotient is one bit; the user keeps x <= d, unenforced.
  assign top = CNT_W'(x) >= d;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= top ? CNT_W'(x) - d : CNT_W'(x);
      q_r[0]   <= {top, {K{1'b0}}};
      d_r[0]   <= d;
      o_r[0]   <= o;
    end
  end

  for (genvar i = 0; i < K; i++) begin : g_step
    logic [CNT_W:0] t;
    logic           ge;
    assign t  = {rem_r[i], o_r[i][K-1-i]};
    assign ge = t >= {1'b0, d_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? CNT_W'(t - {1'b0, d_r[i]}) : CNT_W'(t);
        q_r[i+1]   <= q_r[i] | ({{K{1'b0}}, ge} << (K-1-i));
        d_r[i+1]   <= d_r[i];
        o_r[i+1]   <= o_r[i];
      end
    end
  end

  assign q = q_r[K];
endmodule
`default_nettype wire

@@ sv/uvs_cordic.sv @@
// Pipelined rotation CORDIC: phase in turns to cosine and sine in Q30.
// One stage scales the phase, thirty rotate, one maps the quadrant. Uses uvs_pkg.
`default_nettype none
module uvs_cordic (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [uvs_pkg::PHASE_W-1:0] phase,
  output logic signed [31:0]               cos_o,
  output logic signed [31:0]               sin_o
);
  import uvs_pkg::*;

  localparam int XW = 34;
  localparam int ZW = 34;

  logic signed [XW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS+1];
  logic [1:0]           q_r [CORDIC_STEPS+1];
  logic [60:0]          zprod;
  logic signed [XW-1:0] c_nxt, s_nxt;
  logic signed [31:0]   cos_r, sin_r;

  assign zprod = 61'(phase[29:0]) * 61'(HALF_PI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= XW'(CORDIC_START);
      y_r[0] <= '0;
      z_r[0] <= $signed({3'b000, zprod[60:30]});
      q_r[0] <= phase[31:30];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] ang;
    logic                 neg;
    assign dx  = y_r[i] >>> i;
    assign dy  = x_r[i] >>> i;
    assign ang = $signed({2'b00, ATAN_Q30[i]});
    assign neg = z_r[i][ZW-1];
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= neg ? x_r[i] + dx : x_r[i] - dx;
        y_r[i+1] <= neg ? y_r[i] - dy : y_r[i] + dy;
        z_r[i+1] <= neg ? z_r[i] + ang : z_r[i] - ang;
        q_r[i+1] <= q_r[i];
      end
    end
  end

  always_comb begin
    case (q_r[CORDIC_STEPS])
      2'd0: begin
        c_nxt = x_r[CORDIC_STEPS];
        s_nxt = y_r[CORDIC_STEPS];
      end
      2'd1: begin
        c_nxt = -y_r[CORDIC_STEPS];
        s_nxt = x_r[CORDIC_STEPS];
      end
      2'd2: begin
        c_nxt = -x_r[CORDIC_STEPS];
        s_nxt = -y_r[CORDIC_STEPS];
      end
      default: begin
        c_nxt = y_r[CORDIC_STEPS];
        s_nxt = -x_r[CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= c_nxt[31:0];
      sin_r <= s_nxt[31:0];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;
endmodule
`default_nettype wire

@@ sv/uvs_combine.sv @@
// Forms the position from the two angle results: products, rounding to
// FRACTION_BITS and clamping, over two stages. Uses uvs_pkg.
`default_nettype none
module uvs_combine #(
  parameter int FRACTION_BITS = uvs_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [31:0]       cos_phi,
  input  wire logic signed [31:0]       sin_phi,
  input  wire logic signed [31:0]       cos_theta,
  input  wire logic signed [31:0]       sin_theta,
  output logic [uvs_pkg::POS_W-1:0]     pos_x,
  output logic [uvs_pkg::POS_W-1:0]     pos_y,
  output logic [uvs_pkg::POS_W-1:0]     pos_z
);
  import uvs_pkg::*;

  localparam int SHX = 60 - FRACTION_BITS;
  localparam int SHY = 30 - FRACTION_BITS;
  localparam logic signed [63:0] LIM    = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] HALF_X = 64'sd1 <<< (SHX - 1);

  function automatic logic signed [63:0] clamp_lim(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > LIM) r = LIM;
    else if (v < -LIM) r = -LIM;
    else r = v;
    return r;
  endfunction

  logic signed [63:0] px_prod, pz_prod;
  logic signed [63:0] px_prod_r, pz_prod_r;
  logic signed [32:0] py_neg_r;
  logic signed [63:0] rx, ry, rz;
  logic signed [63:0] cx, cy, cz;
  logic [POS_W-1:0]   px_r, py_r, pz_r;

  assign px_prod = cos_theta * sin_phi;
  assign pz_prod = sin_theta * sin_phi;

  always_ff @(posedge clk) begin
    if (en) begin
      px_prod_r <= px_prod;
      pz_prod_r <= pz_prod;
      py_neg_r  <= -{cos_phi[31], cos_phi};
    end
  end

  assign rx = (px_prod_r + HALF_X) >>> SHX;
  assign rz = (pz_prod_r + HALF_X) >>> SHX;

  if (SHY > 0) begin : g_ry_round
    assign ry = (64'(py_neg_r) + (64'sd1 <<< (SHY - 1))) >>> SHY;
  end else begin : g_ry_plain
    assign ry = 64'(py_neg_r);
  end

  assign cx = clamp_lim(rx);
  assign cy = clamp_lim(ry);
  assign cz = clamp_lim(rz);

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= cx[POS_W-1:0];
      py_r <= cy[POS_W-1:0];
      pz_r <= cz[POS_W-1:0];
    end
  end

  assign pos_x = px_r;
  assign pos_y = py_r;
  assign pos_z = pz_r;
endmodule
`default_nettype wire

@@ sv/uv_sphere_vertex_generator.sv @@
// Top level of the UV-sphere vertex generator: count registers, input stage, dividers,
// CORDIC units, position stage and output skid. Uses uvs_pkg and the uvs_ design modules.
//
//  Channel   Direction  Transfer when            Contents
//  in_       input      in_tvalid & in_tready    ring number, sector number
//  out_      output     out_tvalid & out_tready  position, texture, indices, flags
//  cfg_      input      cfg_wen                  ring_count, sector_count
//
// One grid point is taken every cycle while in_tready is high. Between the input stage
// and the output register lie the 33-stage phase divider, the 32-stage CORDIC and the
// two-stage position multiply. Reset clears the valid bits and sets both counts to 16.
// A result that meets a stalled output holds in a skid register; in_tready falls the
// cycle after and the whole pipeline then holds, so nothing is lost or repeated.
`default_nettype none
module uv_sphere_vertex_generator #(
  parameter int MAX_RINGS     = uvs_pkg::MAX_RINGS_DEF,
  parameter int MAX_SECTORS   = uvs_pkg::MAX_SECTORS_DEF,
  parameter int FRACTION_BITS = uvs_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // ring_number [7:0], sector_number [15:8]
  input  wire logic [uvs_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // pos_x [15:0], pos_y [31:16], pos_z [47:32], tex_u [64:48], tex_v [81:65],
  // vertex_index [97:82], corner_right [113:98], corner_diagonal [129:114],
  // corner_below [145:130], zero [151:146]
  output logic [uvs_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // quad_valid [0], point_error [1]
  output logic [uvs_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input  wire logic                            cfg_wen,
  input  wire logic [uvs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [uvs_pkg::REG_W-1:0]       cfg_wdata
);
  import uvs_pkg::*;

  localparam int PHASE_LAT = PHASE_W + 1;
  localparam int TEX_LAT   = TEX_FRAC + 1;
  localparam int PIPE_LAT  = PHASE_LAT + CORDIC_STEPS + 2 + 2;
  localparam int TEX_DLY   = PIPE_LAT - TEX_LAT;
  localparam int SIDE_W    = $bits(side_t);
  localparam logic [CNT_W-1:0] RC_MAX = CNT_W'(MAX_RINGS);
  localparam logic [CNT_W-1:0] SC_MAX = CNT_W'(MAX_SECTORS);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);

  logic [REG_W-1:0] ring_count_r, sector_count_r;
  logic [CNT_W-1:0] rc_w, sc_w, rc, sc, rd, sd;
  logic             en;
  logic             a_v_r;
  logic [IN_W-1:0]  a_ring_r, a_sect_r;
  logic [CNT_W+IN_W-1:0] idx_w;
  side_t            side_a, side_o;
  logic             pipe_v;
  logic [PHASE_W:0] phi_q, theta_q;
  logic [TEX_W-1:0] tex_u_q, tex_v_q, tex_u_o, tex_v_o;
  logic signed [31:0] cos_phi, sin_phi, cos_theta, sin_theta;
  logic [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [OUT_TDATA_W-1:0] pipe_tdata;
  logic [OUT_TUSER_W-1:0] pipe_tuser;
  logic             push;
  logic             out_tvalid_r, skid_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r, skid_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r, skid_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r   <= REG_W'(16);
      sector_count_r <= REG_W'(16);
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_addr))
        REG_RING_COUNT:   ring_count_r   <= cfg_wdata;
        REG_SECTOR_COUNT: sector_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rc_w = CNT_W'(ring_count_r);
  assign sc_w = CNT_W'(sector_count_r);
  assign rc   = (rc_w < CNT_MIN) ? CNT_MIN : ((rc_w > RC_MAX) ? RC_MAX : rc_w);
  assign sc   = (sc_w < CNT_MIN) ? CNT_MIN : ((sc_w > SC_MAX) ? SC_MAX : sc_w);
  assign rd   = rc - CNT_W'(1);
  assign sd   = sc - CNT_W'(1);

  // The pipeline moves as one; it halts only while the skid register is full.
  assign en        = !skid_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ring_r <= in_tdata[7:0];
      a_sect_r <= in_tdata[15:8];
    end
  end

  assign idx_w = (CNT_W+IN_W)'(a_ring_r) * (CNT_W+IN_W)'(sc) + (CNT_W+IN_W)'(a_sect_r);

  always_comb begin
    side_a.err   = (CNT_W'(a_ring_r) >= rc) || (CNT_W'(a_sect_r) >= sc);
    side_a.quad  = (CNT_W'(a_ring_r) < rd) && (CNT_W'(a_sect_r) < sd);
    side_a.idx   = idx_w[IDX_W-1:0];
    side_a.right = side_a.quad ? side_a.idx + IDX_W'(1) : '0;
    side_a.diag  = side_a.quad ? side_a.idx + IDX_W'(sc) + IDX_W'(1) : '0;
    side_a.below = side_a.quad ? side_a.idx + IDX_W'(sc) : '0;
  end

  uvs_delay #(.W(SIDE_W + 1), .N(PIPE_LAT)) u_side_dly (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({a_v_r, side_a}), .q({pipe_v, side_o})
  );

  uvs_div #(.K(PHASE_W)) u_phi_div (
    .clk(clk), .en(en), .x(a_ring_r), .d({rd[CNT_W-2:0], 1'b0}),
    .o(PHASE_W'(rd)), .q(phi_q)
  );

  uvs_div #(.K(PHASE_W)) u_theta_div (
    .clk(clk), .en(en), .x(a_sect_r), .d(sd),
    .o(PHASE_W'(sd >> 1)), .q(theta_q)
  );

  uvs_div #(.K(TEX_FRAC)) u_tex_u_div (
    .clk(clk), .en(en), .x(a_sect_r), .d(sd),
    .o(TEX_FRAC'(sd >> 1)), .q(tex_u_q)
  );

  uvs_div #(.K(TEX_FRAC)) u_tex_v_div (
    .clk(clk), .en(en), .x(a_ring_r), .d(rd),
    .o(TEX_FRAC'(rd >> 1)), .q(tex_v_q)
  );

  uvs_delay #(.W(2 * TEX_W), .N(TEX_DLY)) u_tex_dly (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({tex_v_q, tex_u_q}), .q({tex_v_o, tex_u_o})
  );

  // A full turn of theta wraps to zero, so the whole bit of its quotient is dropped.
  uvs_cordic u_phi_cordic (
    .clk(clk), .en(en), .phase(phi_q[PHASE_W-1:0]),
    .cos_o(cos_phi), .sin_o(sin_phi)
  );

  uvs_cordic u_theta_cordic (
    .clk(clk), .en(en), .phase(theta_q[PHASE_W-1:0]),
    .cos_o(cos_theta), .sin_o(sin_theta)
  );

  uvs_combine #(.FRACTION_BITS(FRACTION_BITS)) u_combine (
    .clk(clk), .en(en),
    .cos_phi(cos_phi), .sin_phi(sin_phi),
    .cos_theta(cos_theta), .sin_theta(sin_theta),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
  );

  always_comb begin
    if (side_o.err) begin
      pipe_tdata = '0;
      pipe_tuser = 2'b10;
    end else begin
      pipe_tdata = {6'b0, side_o.below, side_o.diag, side_o.right, side_o.idx,
                    tex_v_o, tex_u_o, pos_z, pos_y, pos_x};
      pipe_tuser = {1'b0, side_o.quad};
    end
  end

  assign push = en && pipe_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_tvalid_r) begin
      out_tvalid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_tvalid_r) begin
      out_tdata_r <= skid_valid_r ? skid_tdata_r : pipe_tdata;
      out_tuser_r <= skid_valid_r ? skid_tuser_r : pipe_tuser;
    end else if (push) begin
      skid_tdata_r <= pipe_tdata;
      skid_tuser_r <= pipe_tuser;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
endmodule
`default_nettype wire

@@ sv/uvs_checker.sv @@
// Port-level checks for the UV-sphere vertex generator and the bind that
// attaches them to the top level. Uses uvs_pkg.
`default_nettype none
module uvs_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [uvs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [uvs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [uvs_pkg::OUT_TUSER_W-1:0] out_tuser,
  input wire logic                            cfg_wen,
  input wire logic [uvs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input wire logic [uvs_pkg::REG_W-1:0]       cfg_wdata
);
  import uvs_pkg::*;

  // A result that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // A point off the grid carries nothing but its flag.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0 && !out_tuser[0])
    else $error("off-grid result carries data");

  a_quad_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[113:98] == out_tdata[97:82] + 16'd1)
    else $error("corner b is not the next vertex");

  a_quad_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[129:114] == out_tdata[145:130] + 16'd1)
    else $error("corner c does not follow corner d");
endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (.*);
`default_nettype wire

@@ bench/tb_uv_sphere_vertex_generator.sv @@
// Self-checking bench for uv_sphere_vertex_generator: random grid points and stalls, listed counts.
// Holds its own fixed-point predictor (phase division, CORDIC, rounding); depends on uvs_pkg.
module tb_uv_sphere_vertex_generator;
  import uvs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 100;

  typedef struct {
    logic [7:0] ring;
    logic [7:0] sector;
  } grid_point_t;

  typedef struct {
    logic signed [15:0] pos_x, pos_y, pos_z;
    logic [16:0]        tex_u, tex_v;
    logic [15:0]        index, right, diag, below;
    logic               quad, err;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  grid_point_t pending_points[$];
  vertex_t     expected_vertices[$];
  logic [8:0]  ring_reg = 9'd16, sector_reg = 9'd16;
  int send_gap = 0, recv_stall = 0;
  bit send_burst = 0, recv_burst = 0;
  int mismatches = 0, points_sent = 0, vertices_seen = 0, cycles = 0;

  uv_sphere_vertex_generator i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_wen, .cfg_addr, .cfg_wdata
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned clamp_count(input logic [8:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic longint limit_pos(input longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint round_down_to(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Rotation CORDIC over the first quadrant, then folded out by the top phase bits.
  function automatic void cordic_sin_cos(input logic [31:0] phase, output longint c,
                                         output longint s);
    longint unsigned rem;
    longint x, y, z, dx, dy;
    rem = {34'd0, phase[29:0]};
    z = longint'((rem * longint'(HALF_PI_Q30)) >> 30);
    x = longint'(CORDIC_START);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic vertex_t sphere_vertex(input grid_point_t p);
    vertex_t v;
    longint unsigned rc, sc, rd, sd, r, s, idx;
    logic [31:0] ph_phi, ph_theta;
    longint cp, sp, ct, st;
    v = '{default: '0};
    rc = clamp_count(ring_reg);
    sc = clamp_count(sector_reg);
    r = p.ring;
    s = p.sector;
    if (r >= rc || s >= sc) begin
      v.err = 1'b1;
      return v;
    end
    rd = rc - 1;
    sd = sc - 1;
    ph_phi = 32'(((r << 32) + rd) / (2 * rd));
    ph_theta = 32'(((s << 32) + (sd >> 1)) / sd);
    cordic_sin_cos(ph_phi, cp, sp);
    cordic_sin_cos(ph_theta, ct, st);
    v.pos_x = 16'(limit_pos(round_down_to(ct * sp, 60 - FRACTION_BITS_DEF)));
    v.pos_y = 16'(limit_pos(round_down_to(-cp, 30 - FRACTION_BITS_DEF)));
    v.pos_z = 16'(limit_pos(round_down_to(st * sp, 60 - FRACTION_BITS_DEF)));
    v.tex_u = 17'(((s << TEX_FRAC) + (sd >> 1)) / sd);
    v.tex_v = 17'(((r << TEX_FRAC) + (rd >> 1)) / rd);
    idx = r * sc + s;
    v.index = 16'(idx);
    if (r < rd && s < sd) begin
      v.quad = 1'b1;
      v.right = 16'(idx + 1);
      v.diag = 16'(idx + sc + 1);
      v.below = 16'(idx + sc);
    end
    return v;
  endfunction

  task automatic compare_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  // Input side: one point per transfer, prediction taken at the moment of the transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_vertices.insert(expected_vertices.size(),
                                 sphere_vertex('{in_tdata[7:0], in_tdata[15:8]}));
        points_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          grid_point_t p;
          p = pending_points.pop_front();
          in_tdata <= {p.sector, p.ring};
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
          send_gap = draw_wait(send_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        vertices_seen++;
        if (expected_vertices.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual tdata %h", $time, out_tdata);
        end else begin
          vertex_t e;
          e = expected_vertices.pop_front();
          compare_field("pos_x", e.pos_x, $signed(out_tdata[15:0]));
          compare_field("pos_y", e.pos_y, $signed(out_tdata[31:16]));
          compare_field("pos_z", e.pos_z, $signed(out_tdata[47:32]));
          compare_field("tex_u", e.tex_u, out_tdata[64:48]);
          compare_field("tex_v", e.tex_v, out_tdata[81:65]);
          compare_field("vertex_index", e.index, out_tdata[97:82]);
          compare_field("corner_right", e.right, out_tdata[113:98]);
          compare_field("corner_diagonal", e.diag, out_tdata[129:114]);
          compare_field("corner_below", e.below, out_tdata[145:130]);
          compare_field("padding", 0, out_tdata[151:146]);
          compare_field("quad_valid", e.quad, out_tuser[0]);
          compare_field("point_error", e.err, out_tuser[1]);
        end
        if ($urandom_range(0, 40) == 0) recv_burst = !recv_burst;
        recv_stall = draw_wait(recv_burst);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // One write per call; the enable is raised and dropped at separate edges.
  task automatic write_count(input cfg_reg_t which, input logic [8:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= which;
    cfg_wdata <= value;
    @(posedge clk);
    if (which == REG_RING_COUNT) ring_reg = value;
    else sector_reg = value;
    cfg_wen <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || in_tvalid || expected_vertices.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic queue_point(input int r, input int s);
    pending_points.insert(pending_points.size(), '{8'(r), 8'(s)});
  endtask

  // Mostly points inside the grid, with some anywhere in the full field range.
  task automatic queue_random(input int n);
    int rc, sc;
    rc = clamp_count(ring_reg);
    sc = clamp_count(sector_reg);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0)
        queue_point($urandom_range(0, 255), $urandom_range(0, 255));
      else
        queue_point($urandom_range(0, rc - 1), $urandom_range(0, sc - 1));
    end
  endtask

  initial begin
    logic [8:0] settings[8][2] = '{
      '{9'd16, 9'd16}, '{9'd2, 9'd2}, '{9'd256, 9'd256}, '{9'd0, 9'd1},
      '{9'd511, 9'd300}, '{9'd3, 9'd257}, '{9'd170, 9'd85}, '{9'd37, 9'd200}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset counts: poles, last ring and sector, points just outside and far outside.
    queue_point(0, 0);   queue_point(15, 15); queue_point(15, 0); queue_point(0, 15);
    queue_point(14, 14); queue_point(16, 0);  queue_point(0, 16); queue_point(255, 255);
    queue_point(8, 4);   queue_point(7, 12);  queue_point(1, 1);
    wait_drained();
    write_count(REG_RING_COUNT, 9'd256);
    write_count(REG_SECTOR_COUNT, 9'd256);
    queue_point(255, 255); queue_point(254, 254); queue_point(0, 255);
    queue_point(128, 64);  queue_point(170, 85);  queue_point(85, 170);
    wait_drained();

    foreach (settings[i]) begin
      write_count(REG_RING_COUNT, settings[i][0]);
      write_count(REG_SECTOR_COUNT, settings[i][1]);
      queue_random(115);
      wait_drained();
    end

    $display("Sent %0d grid points and checked %0d vertices over %0d count settings",
             points_sent, vertices_seen, 10);
    $display("Counts ran from clamped minimum through 511, with random stalls on both sides");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/uvs_pkg.sv
sv/uvs_delay.sv
sv/uvs_div.sv
sv/uvs_cordic.sv
sv/uvs_combine.sv
sv/uv_sphere_vertex_generator.sv
sv/uvs_checker.sv
bench/tb_uv_sphere_vertex_generator.sv
